// ===== src/r4ntt_pkg.sv =====
// Package for the radix-4 NTT butterfly core: field widths, configuration
// register indexes and reset values, and the stage-enable bundle of the REDC unit.
// No dependencies.
package r4ntt_pkg;

    // Width of every coefficient, twiddle and result port.
    localparam int FIELD_W = 31;
    // Widest configuration register and widest lane supported.
    localparam int CFG_DATA_W = 32;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_INVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_UNIT   = 2'd2;

    // Register values after reset.
    localparam logic [FIELD_W-1:0]    MODULUS_RESET     = 31'd469762049;
    localparam logic [CFG_DATA_W-1:0] NEG_INVERSE_RESET = 32'd469762047;
    localparam logic [FIELD_W-1:0]    IMAG_UNIT_RESET   = 31'd0;

    // Number of register stages in one Montgomery multiplier.
    localparam int REDC_STAGES = 5;

    // One load enable for each register stage of the Montgomery multiplier.
    typedef struct packed {
        logic mul;    // a * b
        logic lo;     // low half times -m^-1
        logic mm;     // u * m
        logic fold;   // add and keep the upper half
        logic norm;   // final conditional subtract
    } redc_adv_t;

endpackage

// ===== src/r4ntt_redc.sv =====
// Five-stage Montgomery multiplier (REDC with one conditional subtract).
// Depends on r4ntt_pkg for the stage-enable bundle.
module r4ntt_redc
    import r4ntt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  redc_adv_t            adv,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] modulus,
    input  logic [WORD_BITS-1:0] neg_inverse,
    output logic [WORD_BITS-1:0] result
);

    localparam int PROD_W = 2 * WORD_BITS;

    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_b_reg;
    logic [PROD_W-1:0]    prod_c_reg;
    logic [PROD_W-1:0]    um_reg;
    logic [WORD_BITS-1:0] u_reg;
    logic [WORD_BITS-1:0] hi_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [PROD_W-1:0]    fold_sum;

    // The carry out of the double-width sum falls outside the kept bits.
    assign fold_sum = prod_c_reg + um_reg;

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
        if (adv.lo)
        begin
            u_reg      <= WORD_BITS'(prod_reg[WORD_BITS-1:0] * neg_inverse);
            prod_b_reg <= prod_reg;
        end
        if (adv.mm)
        begin
            um_reg     <= PROD_W'(u_reg) * PROD_W'(modulus);
            prod_c_reg <= prod_b_reg;
        end
        if (adv.fold)
        begin
            hi_reg <= fold_sum[PROD_W-1:WORD_BITS];
        end
        if (adv.norm)
        begin
            res_reg <= (hi_reg >= modulus) ? hi_reg - modulus : hi_reg;
        end
    end

    assign result = res_reg;

endmodule

// ===== src/radix4_ntt_butterfly_montgomery_core.sv =====
// Top level of the radix-4 decimation-in-frequency NTT butterfly core.
// Depends on r4ntt_pkg and instantiates r4ntt_redc four times.
//
// Usage: one input transaction carries four coefficients coef_0..coef_3 and
// three twiddles twiddle_1..twiddle_3, all in Montgomery form below the
// modulus. One output transaction returns out_0..out_3 of the butterfly:
// out_0 is the sum of all four coefficients, outputs one to three are the
// mixed sums and differences multiplied by their twiddles with Montgomery
// REDC. Both channels use a valid/ready handshake.
// The modulus, -m^-1 mod 2^WORD_BITS and the fourth root of unity are set
// through the write port (cfg_write, cfg_index, cfg_data) while no
// transaction is in flight; writes to an unused index are ignored.
// There are twelve register stages; the first one loads at the accepting edge.
// Stage 0 forms the sums and differences, five stages multiply by the root of
// unity, one forms the second sum level and five run the twiddle multipliers.
// Each multiplier stage holds one 32x32 product, the wide add or the final subtract.
// Throughput is one transaction per cycle while the receiver does not stall.
// Every stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so bubbles close up while the receiver stalls and
// in_ready falls only once all 12 stages are full. Reset empties the pipeline
// and loads the registers with their default values.
module radix4_ntt_butterfly_montgomery_core
    import r4ntt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FIELD_W-1:0]    coef_0,
    input  logic [FIELD_W-1:0]    coef_1,
    input  logic [FIELD_W-1:0]    coef_2,
    input  logic [FIELD_W-1:0]    coef_3,
    input  logic [FIELD_W-1:0]    twiddle_1,
    input  logic [FIELD_W-1:0]    twiddle_2,
    input  logic [FIELD_W-1:0]    twiddle_3,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FIELD_W-1:0]    out_0,
    output logic [FIELD_W-1:0]    out_1,
    output logic [FIELD_W-1:0]    out_2,
    output logic [FIELD_W-1:0]    out_3
);

    // Stage map: stage 0 forms the first sums, stages 1 to 5 multiply by the
    // root of unity, stage 6 forms the second sums, stages 7 to 11 apply twiddles.
    localparam int NUM_STAGES = 2 + 2 * REDC_STAGES;
    localparam int MIX_STAGE  = 1 + REDC_STAGES;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    typedef logic [WORD_BITS-1:0] lane_t;

    // Sum in the lane, wrapping, then one conditional subtract.
    function automatic lane_t norm_f(input lane_t x, input lane_t m);
        return (x >= m) ? x - m : x;
    endfunction

    function automatic lane_t add_f(input lane_t a, input lane_t b, input lane_t m);
        lane_t s;
        s = a + b;
        return norm_f(s, m);
    endfunction

    // Difference taken as a + m - b in the lane.
    function automatic lane_t sub_f(input lane_t a, input lane_t b, input lane_t m);
        lane_t s;
        s = a + m;
        s = s - b;
        return norm_f(s, m);
    endfunction

    // Configuration registers.
    logic [FIELD_W-1:0]    modulus_reg;
    logic [CFG_DATA_W-1:0] neg_inverse_reg;
    logic [FIELD_W-1:0]    imag_unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= MODULUS_RESET;
            neg_inverse_reg <= NEG_INVERSE_RESET;
            imag_unit_reg   <= IMAG_UNIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS:     modulus_reg     <= cfg_data[FIELD_W-1:0];
                REG_NEG_INVERSE: neg_inverse_reg <= cfg_data;
                REG_IMAG_UNIT:   imag_unit_reg   <= cfg_data[FIELD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Register values cut or extended to the lane.
    lane_t m_lane;
    lane_t ninv_lane;
    lane_t j_lane;

    assign m_lane    = WORD_BITS'(modulus_reg);
    assign ninv_lane = neg_inverse_reg[WORD_BITS-1:0];
    assign j_lane    = WORD_BITS'(imag_unit_reg);

    // Pipeline control. A stage loads when it is empty or its successor loads.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    assign adv[LAST_STAGE] = !valid_reg[LAST_STAGE] || out_ready;

    genvar gs;
    generate
        for (gs = 0; gs < LAST_STAGE; gs++)
        begin : g_adv
            assign adv[gs] = !valid_reg[gs] || adv[gs+1];
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[LAST_STAGE];

    // Stage 0 and the copies that ride along with the first multiplier.
    // Index 0 is stage 0; index i is stage i.
    lane_t t0_pipe_reg [MIX_STAGE];
    lane_t t1_pipe_reg [MIX_STAGE];
    lane_t t2_pipe_reg [MIX_STAGE];
    lane_t w1_pipe_reg [MIX_STAGE+1];
    lane_t w2_pipe_reg [MIX_STAGE+1];
    lane_t w3_pipe_reg [MIX_STAGE+1];
    lane_t diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t0_pipe_reg[0] <= add_f(WORD_BITS'(coef_0), WORD_BITS'(coef_2), m_lane);
            t1_pipe_reg[0] <= sub_f(WORD_BITS'(coef_0), WORD_BITS'(coef_2), m_lane);
            t2_pipe_reg[0] <= add_f(WORD_BITS'(coef_1), WORD_BITS'(coef_3), m_lane);
            diff_reg       <= sub_f(WORD_BITS'(coef_1), WORD_BITS'(coef_3), m_lane);
            w1_pipe_reg[0] <= WORD_BITS'(twiddle_1);
            w2_pipe_reg[0] <= WORD_BITS'(twiddle_2);
            w3_pipe_reg[0] <= WORD_BITS'(twiddle_3);
        end
        for (int k = 1; k < MIX_STAGE; k++)
        begin
            if (adv[k])
            begin
                t0_pipe_reg[k] <= t0_pipe_reg[k-1];
                t1_pipe_reg[k] <= t1_pipe_reg[k-1];
                t2_pipe_reg[k] <= t2_pipe_reg[k-1];
            end
        end
        for (int k = 1; k <= MIX_STAGE; k++)
        begin
            if (adv[k])
            begin
                w1_pipe_reg[k] <= w1_pipe_reg[k-1];
                w2_pipe_reg[k] <= w2_pipe_reg[k-1];
                w3_pipe_reg[k] <= w3_pipe_reg[k-1];
            end
        end
    end

    // Odd difference times the fourth root of unity.
    redc_adv_t adv_rot;
    lane_t     t3_lane;

    assign adv_rot.mul  = adv[1];
    assign adv_rot.lo   = adv[2];
    assign adv_rot.mm   = adv[3];
    assign adv_rot.fold = adv[4];
    assign adv_rot.norm = adv[5];

    r4ntt_redc #(
        .WORD_BITS (WORD_BITS)
    ) u_redc_rot (
        .clk         (clk),
        .adv         (adv_rot),
        .a           (diff_reg),
        .b           (j_lane),
        .modulus     (m_lane),
        .neg_inverse (ninv_lane),
        .result      (t3_lane)
    );

    // Stage 6: second level of sums and differences.
    lane_t y1_reg;
    lane_t y2_reg;
    lane_t y3_reg;
    lane_t y0_pipe_reg [REDC_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (adv[MIX_STAGE])
        begin
            y0_pipe_reg[0] <= add_f(t0_pipe_reg[MIX_STAGE-1], t2_pipe_reg[MIX_STAGE-1], m_lane);
            y1_reg         <= add_f(t1_pipe_reg[MIX_STAGE-1], t3_lane, m_lane);
            y2_reg         <= sub_f(t0_pipe_reg[MIX_STAGE-1], t2_pipe_reg[MIX_STAGE-1], m_lane);
            y3_reg         <= sub_f(t1_pipe_reg[MIX_STAGE-1], t3_lane, m_lane);
        end
        for (int k = 1; k <= REDC_STAGES; k++)
        begin
            if (adv[MIX_STAGE+k])
            begin
                y0_pipe_reg[k] <= y0_pipe_reg[k-1];
            end
        end
    end

    // Stages 7 to 11: the three twiddle multipliers run side by side.
    redc_adv_t adv_tw;
    lane_t     z1_lane;
    lane_t     z2_lane;
    lane_t     z3_lane;

    assign adv_tw.mul  = adv[MIX_STAGE+1];
    assign adv_tw.lo   = adv[MIX_STAGE+2];
    assign adv_tw.mm   = adv[MIX_STAGE+3];
    assign adv_tw.fold = adv[MIX_STAGE+4];
    assign adv_tw.norm = adv[MIX_STAGE+5];

    r4ntt_redc #(
        .WORD_BITS (WORD_BITS)
    ) u_redc_tw1 (
        .clk         (clk),
        .adv         (adv_tw),
        .a           (y1_reg),
        .b           (w1_pipe_reg[MIX_STAGE]),
        .modulus     (m_lane),
        .neg_inverse (ninv_lane),
        .result      (z1_lane)
    );

    r4ntt_redc #(
        .WORD_BITS (WORD_BITS)
    ) u_redc_tw2 (
        .clk         (clk),
        .adv         (adv_tw),
        .a           (y2_reg),
        .b           (w2_pipe_reg[MIX_STAGE]),
        .modulus     (m_lane),
        .neg_inverse (ninv_lane),
        .result      (z2_lane)
    );

    r4ntt_redc #(
        .WORD_BITS (WORD_BITS)
    ) u_redc_tw3 (
        .clk         (clk),
        .adv         (adv_tw),
        .a           (y3_reg),
        .b           (w3_pipe_reg[MIX_STAGE]),
        .modulus     (m_lane),
        .neg_inverse (ninv_lane),
        .result      (z3_lane)
    );

    assign out_0 = FIELD_W'(y0_pipe_reg[REDC_STAGES]);
    assign out_1 = FIELD_W'(z1_lane);
    assign out_2 = FIELD_W'(z2_lane);
    assign out_3 = FIELD_W'(z3_lane);

`ifndef SYNTHESIS
    // An accepted transaction always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transaction did not enter the first stage");

    // The input side is only held off when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("in_ready low while the pipeline has room");

    // A full stage 5 whose successor, stage 6, does not load keeps its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[MIX_STAGE-1] && !adv[MIX_STAGE] |=> valid_reg[MIX_STAGE-1])
        else $error("transaction dropped at the end of the first multiplier");

    // A result leaves the pipeline only through an output handshake.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result vanished without being taken");
`endif

endmodule
